// ----- hdl/scra_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package scra_pkg;

    localparam int MAX_FACES_DEF       = 4096;
    localparam int MAX_ENTRIES_DEF     = 1024;
    localparam int CACHE_ADDR_BITS_DEF = 20;
    localparam int HEADER_BYTES_DEF    = 8;

    localparam int RING_W     = 21;
    localparam int SIZE_W     = 17;
    localparam int DIM_W      = 9;
    localparam int OFF_W      = 20;
    localparam int FIELD_W    = 12;
    localparam int MIP_W      = 2;
    localparam int FACE_LIMIT = 256;

    localparam logic [RING_W-1:0] CACHE_BYTES_RST = 21'd1048576;

    localparam int TBL_W = 1 + MIP_W + RING_W + 2 * DIM_W;

    localparam logic [1:0] REG_CACHE_BYTES = 2'd0;

    typedef struct packed {
        logic rd;
        logic wr;
    } mem_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/scra_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module scra_ram
    import scra_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int DW    = 8
) (
    input  wire logic                     clk,
    input  wire mem_ctrl_t                ctrl,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DW-1:0]            wdata,
    output logic      [DW-1:0]            rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctrl.wr)
        begin
            mem[waddr] <= wdata;
        end
        if (ctrl.rd)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/scra_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module scra_seq
    import scra_pkg::*;
#(
    parameter int MAX_FACES       = MAX_FACES_DEF,
    parameter int MAX_ENTRIES     = MAX_ENTRIES_DEF,
    parameter int CACHE_ADDR_BITS = CACHE_ADDR_BITS_DEF,
    parameter int HEADER_BYTES    = HEADER_BYTES_DEF,
    localparam int FACE_AW = $clog2(MAX_FACES),
    localparam int ENT_AW  = $clog2(MAX_ENTRIES),
    localparam int FIFO_W  = RING_W + SIZE_W + FACE_AW
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                flush,
    input  wire logic [RING_W-1:0]   flush_bytes,
    input  wire logic [RING_W-1:0]   cache_bytes,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [FIELD_W-1:0]  face_index,
    input  wire logic [MIP_W-1:0]    lod_level,
    input  wire logic [FIELD_W-1:0]  face_width,
    input  wire logic [FIELD_W-1:0]  face_height,
    output logic                     res_valid,
    input  wire logic                res_ready,
    output logic                     res_hit,
    output logic                     res_too_large,
    output logic [OFF_W-1:0]         res_offset,
    output logic [DIM_W-1:0]         res_width,
    output logic [DIM_W-1:0]         res_height,
    output mem_ctrl_t                tbl_ctrl,
    output logic [FACE_AW-1:0]       tbl_raddr,
    output logic [FACE_AW-1:0]       tbl_waddr,
    output logic [TBL_W-1:0]         tbl_wdata,
    input  wire logic [TBL_W-1:0]    tbl_rdata,
    output mem_ctrl_t                fifo_ctrl,
    output logic [ENT_AW-1:0]        fifo_raddr,
    output logic [ENT_AW-1:0]        fifo_waddr,
    output logic [FIFO_W-1:0]        fifo_wdata,
    input  wire logic [FIFO_W-1:0]   fifo_rdata
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [31:0] CapLim = 32'(1) << CACHE_ADDR_BITS;

    typedef enum logic [11:0] {
        S_CLEAR = 12'b000000000001,
        S_IDLE  = 12'b000000000010,
        S_MOD   = 12'b000000000100,
        S_TRD   = 12'b000000001000,
        S_CHK   = 12'b000000010000,
        S_MUL   = 12'b000000100000,
        S_FIT   = 12'b000001000000,
        S_ERD   = 12'b000010000000,
        S_EDEC  = 12'b000100000000,
        S_EVICT = 12'b001000000000,
        S_PUSH  = 12'b010000000000,
        S_DONE  = 12'b100000000000
    } state_t;

    typedef enum logic [2:0] {
        M_WRAP = 3'b001,
        M_LOOP = 3'b010,
        M_FULL = 3'b100
    } mode_t;

    state_t               state_reg, state_next;
    mode_t                mode_reg, mode_next;
    logic [FACE_AW-1:0]   clr_reg, clr_next;
    logic [RING_W-1:0]    head_reg, head_next;
    logic [RING_W-1:0]    tail_reg, tail_next;
    logic [RING_W-1:0]    end_reg, end_next;
    logic [ENT_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [ENT_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;

    logic [FIELD_W-1:0]   face_reg, face_next;
    logic [MIP_W-1:0]     mip_reg, mip_next;
    logic [FIELD_W-1:0]   fw_reg, fw_next;
    logic [FIELD_W-1:0]   fh_reg, fh_next;
    logic [DIM_W-1:0]     w_reg, w_next;
    logic [DIM_W-1:0]     h_reg, h_next;
    logic [SIZE_W-1:0]    size_reg, size_next;
    logic                 hit_reg, hit_next;
    logic                 tl_reg, tl_next;
    logic [OFF_W-1:0]     off_reg, off_next;
    logic [DIM_W-1:0]     rw_reg, rw_next;
    logic [DIM_W-1:0]     rh_reg, rh_next;

    logic [RING_W-1:0]    cap;
    logic [RING_W:0]      tail_sum;
    logic                 need_space;
    logic                 over_cap;
    logic [FACE_AW-1:0]   face_addr;

    logic                 t_res;
    logic [MIP_W-1:0]     t_mip;
    logic [RING_W-1:0]    t_off;
    logic [DIM_W-1:0]     t_w;
    logic [DIM_W-1:0]     t_h;
    logic [RING_W-1:0]    f_off;
    logic [SIZE_W-1:0]    f_size;
    logic [FACE_AW-1:0]   f_face;
    logic [2*DIM_W-1:0]   prod;

    assign cap = ({11'b0, cache_bytes} > CapLim) ? RING_W'(CapLim) : cache_bytes;

    // shared adder and comparators for the ring checks
    assign tail_sum   = {1'b0, tail_reg} + (RING_W + 1)'(size_reg);
    assign need_space = tail_sum > {1'b0, head_reg};
    assign over_cap   = tail_sum > {1'b0, cap};
    assign face_addr  = FACE_AW'(face_reg);

    assign {t_res, t_mip, t_off, t_w, t_h} = tbl_rdata;
    assign {f_off, f_size, f_face}         = fifo_rdata;
    assign prod = w_reg * h_reg;

    function automatic logic [ENT_AW-1:0] next_slot(input logic [ENT_AW-1:0] p);
        logic [ENT_AW-1:0] r;
        if (p == ENT_AW'(MAX_ENTRIES - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    assign in_ready      = (state_reg == S_IDLE);
    assign res_valid     = (state_reg == S_DONE);
    assign res_hit       = hit_reg;
    assign res_too_large = tl_reg;
    assign res_offset    = off_reg;
    assign res_width     = rw_reg;
    assign res_height    = rh_reg;

    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        clr_next    = clr_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        end_next    = end_reg;
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        cnt_next    = cnt_reg;
        face_next   = face_reg;
        mip_next    = mip_reg;
        fw_next     = fw_reg;
        fh_next     = fh_reg;
        w_next      = w_reg;
        h_next      = h_reg;
        size_next   = size_reg;
        hit_next    = hit_reg;
        tl_next     = tl_reg;
        off_next    = off_reg;
        rw_next     = rw_reg;
        rh_next     = rh_reg;
        tbl_ctrl    = '0;
        tbl_raddr   = face_addr;
        tbl_waddr   = face_addr;
        tbl_wdata   = '0;
        fifo_ctrl   = '0;
        fifo_raddr  = rd_ptr_reg;
        fifo_waddr  = wr_ptr_reg;
        fifo_wdata  = {tail_reg, size_reg, face_addr};

        unique case (state_reg)
            S_CLEAR:
            begin
                tbl_ctrl.wr = 1'b1;
                tbl_waddr   = clr_reg;
                clr_next    = clr_reg + 1'b1;
                if (clr_reg == FACE_AW'(MAX_FACES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    face_next  = face_index;
                    mip_next   = lod_level;
                    fw_next    = face_width;
                    fh_next    = face_height;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                // fold the face index into the table range
                if ({20'b0, face_reg} >= 32'(MAX_FACES))
                begin
                    face_next = face_reg - FIELD_W'(MAX_FACES);
                end
                else
                begin
                    state_next = S_TRD;
                end
            end
            S_TRD:
            begin
                tbl_ctrl.rd = 1'b1;
                state_next  = S_CHK;
            end
            S_CHK:
            begin
                hit_next = 1'b0;
                tl_next  = 1'b0;
                off_next = '0;
                rw_next  = '0;
                rh_next  = '0;
                if (t_res && t_mip == mip_reg)
                begin
                    hit_next   = 1'b1;
                    off_next   = t_off[OFF_W-1:0];
                    rw_next    = t_w;
                    rh_next    = t_h;
                    state_next = S_DONE;
                end
                else if (fw_reg > FIELD_W'(FACE_LIMIT) || fh_reg > FIELD_W'(FACE_LIMIT))
                begin
                    tl_next    = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    w_next     = DIM_W'(fw_reg >> mip_reg);
                    h_next     = DIM_W'(fh_reg >> mip_reg);
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                size_next  = SIZE_W'(prod + (2*DIM_W)'(HEADER_BYTES));
                state_next = S_FIT;
            end
            S_FIT:
            begin
                if ({4'b0, size_reg} > cap)
                begin
                    tl_next    = 1'b1;
                    state_next = S_DONE;
                end
                else if (need_space)
                begin
                    if (over_cap)
                    begin
                        end_next  = tail_reg;
                        head_next = '0;
                        tail_next = '0;
                        mode_next = M_WRAP;
                    end
                    else
                    begin
                        mode_next = M_LOOP;
                    end
                    state_next = S_ERD;
                end
                else
                begin
                    mode_next  = M_FULL;
                    state_next = S_ERD;
                end
            end
            S_ERD:
            begin
                fifo_ctrl.rd = 1'b1;
                state_next   = S_EDEC;
            end
            S_EDEC:
            begin
                tbl_raddr = f_face;
                unique case (mode_reg)
                    M_WRAP:
                    begin
                        // drop entries stranded past the old tail
                        if (cnt_reg != '0 && f_off >= end_reg)
                        begin
                            tbl_ctrl.rd = 1'b1;
                            state_next  = S_EVICT;
                        end
                        else
                        begin
                            mode_next = M_LOOP;
                        end
                    end
                    M_LOOP:
                    begin
                        if (!need_space)
                        begin
                            mode_next = M_FULL;
                        end
                        else if (head_reg >= end_reg || cnt_reg == '0 || f_off < head_reg)
                        begin
                            head_next = cap;
                        end
                        else
                        begin
                            tbl_ctrl.rd = 1'b1;
                            state_next  = S_EVICT;
                        end
                    end
                    M_FULL:
                    begin
                        if (cnt_reg >= CNT_W'(MAX_ENTRIES))
                        begin
                            tbl_ctrl.rd = 1'b1;
                            state_next  = S_EVICT;
                        end
                        else
                        begin
                            state_next = S_PUSH;
                        end
                    end
                    default:
                    begin
                        mode_next = M_FULL;
                    end
                endcase
            end
            S_EVICT:
            begin
                if (t_res && t_off == f_off)
                begin
                    tbl_ctrl.wr = 1'b1;
                    tbl_waddr   = f_face;
                    tbl_wdata   = {1'b0, tbl_rdata[TBL_W-2:0]};
                end
                rd_ptr_next = next_slot(rd_ptr_reg);
                cnt_next    = cnt_reg - 1'b1;
                if (mode_reg == M_LOOP)
                begin
                    head_next = RING_W'({1'b0, f_off} + (RING_W + 1)'(f_size));
                end
                state_next = S_ERD;
            end
            S_PUSH:
            begin
                fifo_ctrl.wr = 1'b1;
                tbl_ctrl.wr  = 1'b1;
                tbl_wdata    = {1'b1, mip_reg, tail_reg, w_reg, h_reg};
                hit_next     = 1'b0;
                tl_next      = 1'b0;
                off_next     = tail_reg[OFF_W-1:0];
                rw_next      = w_reg;
                rh_next      = h_reg;
                tail_next    = tail_sum[RING_W-1:0];
                if (tail_sum > {1'b0, end_reg})
                begin
                    end_next = tail_sum[RING_W-1:0];
                end
                wr_ptr_next = next_slot(wr_ptr_reg);
                cnt_next    = cnt_reg + 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (flush)
        begin
            state_next  = S_CLEAR;
            clr_next    = '0;
            head_next   = '0;
            tail_next   = flush_bytes;
            end_next    = '0;
            rd_ptr_next = '0;
            wr_ptr_next = '0;
            cnt_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            mode_reg   <= M_FULL;
            clr_reg    <= '0;
            head_reg   <= '0;
            tail_reg   <= CACHE_BYTES_RST;
            end_reg    <= '0;
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            clr_reg    <= clr_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            end_reg    <= end_next;
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        face_reg <= face_next;
        mip_reg  <= mip_next;
        fw_reg   <= fw_next;
        fh_reg   <= fh_next;
        w_reg    <= w_next;
        h_reg    <= h_next;
        size_reg <= size_next;
        hit_reg  <= hit_next;
        tl_reg   <= tl_next;
        off_reg  <= off_next;
        rw_reg   <= rw_next;
        rh_reg   <= rh_next;
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count above depth");

    a_evict_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EVICT |-> cnt_reg != '0)
        else $error("eviction from empty entry queue");

    a_result_excl: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE |-> !(hit_reg && tl_reg))
        else $error("hit and refusal together");

    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PUSH |-> tail_sum <= {1'b0, cap})
        else $error("allocation past usable end");
`endif

endmodule

`default_nettype wire

// ----- hdl/surface_cache_ring_allocator.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready   face_index, lod_level, face_width, face_height
// out       output     out_valid / out_ready hit, too_large, offset, width, height
// apb       input      psel/penable/pready   paddr, pwrite, pwdata, prdata (cache_bytes)
//
// A hit or a dimension refusal shows on out after the table read and check; a size
// refusal also passes the multiply and fit test; an allocation adds the entry reads and
// evictions, head jumps, mode steps and the push; index folding adds states too. All steps
// are paced by the one-read one-write face table and entry queue under one sequencer, and a
// full output register stalls it. After reset, and after every cache_bytes write, a
// clearing pass runs over the face table with in_ready low.
// A result waits in the output register; the next item is taken while it waits.

module surface_cache_ring_allocator
    import scra_pkg::*;
#(
    parameter int MAX_FACES       = MAX_FACES_DEF,
    parameter int MAX_ENTRIES     = MAX_ENTRIES_DEF,
    parameter int CACHE_ADDR_BITS = CACHE_ADDR_BITS_DEF,
    parameter int HEADER_BYTES    = HEADER_BYTES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [1:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [FIELD_W-1:0] face_index,
    input  wire logic [MIP_W-1:0]   lod_level,
    input  wire logic [FIELD_W-1:0] face_width,
    input  wire logic [FIELD_W-1:0] face_height,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    hit,
    output logic                    too_large,
    output logic [OFF_W-1:0]        offset,
    output logic [DIM_W-1:0]        width,
    output logic [DIM_W-1:0]        height
);

    localparam int FACE_AW = $clog2(MAX_FACES);
    localparam int ENT_AW  = $clog2(MAX_ENTRIES);
    localparam int FIFO_W  = RING_W + SIZE_W + FACE_AW;

    logic [RING_W-1:0]  cache_bytes_reg;
    logic               cfg_wr;
    logic               out_valid_reg;
    logic               res_valid;
    logic               res_ready;
    logic               res_hit;
    logic               res_too_large;
    logic [OFF_W-1:0]   res_offset;
    logic [DIM_W-1:0]   res_width;
    logic [DIM_W-1:0]   res_height;
    logic               hit_reg;
    logic               tl_reg;
    logic [OFF_W-1:0]   off_reg;
    logic [DIM_W-1:0]   w_reg;
    logic [DIM_W-1:0]   h_reg;

    mem_ctrl_t          tbl_ctrl;
    logic [FACE_AW-1:0] tbl_raddr;
    logic [FACE_AW-1:0] tbl_waddr;
    logic [TBL_W-1:0]   tbl_wdata;
    logic [TBL_W-1:0]   tbl_rdata;
    mem_ctrl_t          fifo_ctrl;
    logic [ENT_AW-1:0]  fifo_raddr;
    logic [ENT_AW-1:0]  fifo_waddr;
    logic [FIFO_W-1:0]  fifo_wdata;
    logic [FIFO_W-1:0]  fifo_rdata;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == REG_CACHE_BYTES);
    assign prdata = (paddr == REG_CACHE_BYTES) ? {11'b0, cache_bytes_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cache_bytes_reg <= CACHE_BYTES_RST;
        end
        else if (cfg_wr)
        begin
            cache_bytes_reg <= pwdata[RING_W-1:0];
        end
    end

    // output stage: load a finished result whenever the register is free or drains
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            hit_reg <= res_hit;
            tl_reg  <= res_too_large;
            off_reg <= res_offset;
            w_reg   <= res_width;
            h_reg   <= res_height;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign too_large = tl_reg;
    assign offset    = off_reg;
    assign width     = w_reg;
    assign height    = h_reg;

    scra_seq #(
        .MAX_FACES       (MAX_FACES),
        .MAX_ENTRIES     (MAX_ENTRIES),
        .CACHE_ADDR_BITS (CACHE_ADDR_BITS),
        .HEADER_BYTES    (HEADER_BYTES)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .flush         (cfg_wr),
        .flush_bytes   (pwdata[RING_W-1:0]),
        .cache_bytes   (cache_bytes_reg),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .face_index    (face_index),
        .lod_level     (lod_level),
        .face_width    (face_width),
        .face_height   (face_height),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res_hit       (res_hit),
        .res_too_large (res_too_large),
        .res_offset    (res_offset),
        .res_width     (res_width),
        .res_height    (res_height),
        .tbl_ctrl      (tbl_ctrl),
        .tbl_raddr     (tbl_raddr),
        .tbl_waddr     (tbl_waddr),
        .tbl_wdata     (tbl_wdata),
        .tbl_rdata     (tbl_rdata),
        .fifo_ctrl     (fifo_ctrl),
        .fifo_raddr    (fifo_raddr),
        .fifo_waddr    (fifo_waddr),
        .fifo_wdata    (fifo_wdata),
        .fifo_rdata    (fifo_rdata)
    );

    scra_ram #(
        .DEPTH (MAX_FACES),
        .DW    (TBL_W)
    ) u_face_table (
        .clk   (clk),
        .ctrl  (tbl_ctrl),
        .raddr (tbl_raddr),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .rdata (tbl_rdata)
    );

    scra_ram #(
        .DEPTH (MAX_ENTRIES),
        .DW    (FIFO_W)
    ) u_entry_fifo (
        .clk   (clk),
        .ctrl  (fifo_ctrl),
        .raddr (fifo_raddr),
        .waddr (fifo_waddr),
        .wdata (fifo_wdata),
        .rdata (fifo_rdata)
    );

endmodule

`default_nettype wire
